// ===== hw/rtl/tkbd_pkg.sv =====
package tkbd_pkg;

  // Converter and arithmetic widths
  localparam int unsigned AdcBits     = 12;
  localparam int unsigned SumBits     = 16;
  localparam int unsigned GainBits    = 11;
  localparam int unsigned GainShift   = 10;
  localparam int unsigned MixBits     = SumBits + GainBits + 1;
  localparam int unsigned DataBits    = 32;
  localparam int unsigned DenBits     = 16;
  localparam int unsigned IntegBits   = 21;
  localparam int unsigned DivBits     = 32;
  localparam int unsigned DivCntBits  = $clog2(DivBits);
  localparam int unsigned CfgAddrBits = 5;

  // Algorithm constants
  localparam logic [3:0]          GroupLen      = 4'd10;
  localparam logic [3:0]          SettleLimit   = 4'd10;
  localparam logic [GainBits-1:0] GainOne       = 11'd1024;
  localparam logic [DataBits-1:0] BaselineReset = 32'h0000_FFFF;

  // x / 10 for 16-bit x as (x * 0xCCCD) >> 19
  localparam logic [SumBits-1:0] Recip10      = 16'hCCCD;
  localparam int unsigned        Recip10Shift = 19;

  // Configuration register map (word index)
  typedef enum logic [2:0] {
    RegThreshold = 3'd0,
    RegGain      = 3'd1,
    RegPropDiv   = 3'd2,
    RegIntegDiv  = 3'd3,
    RegIntegMax  = 3'd4,
    RegIntegMin  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [15:0]          thr;
    logic [GainBits-1:0]  gain;
    logic [DenBits-1:0]   prop;
    logic [DenBits-1:0]   integ;
    logic [IntegBits-1:0] imax;
    logic [IntegBits-1:0] imin;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic tick;
    logic avg;
    logic mul;
    logic mix;
    logic diff;
    logic decide;
    logic pi_step;
    logic div_start;
    logic div_sel;
    logic cap_p;
    logic cap_base;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic group_end;
    logic take_pi;
    logic d_zero;
    logic div_busy;
    logic div_done;
  } dp_status_t;

endpackage

// ===== hw/rtl/tkbd_in_if.sv =====
interface tkbd_in_if;
  logic                          valid;
  logic                          ready;
  logic [tkbd_pkg::AdcBits-1:0]  adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

// ===== hw/rtl/tkbd_out_if.sv =====
interface tkbd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          evaluated;
  logic                          touching;
  logic                          ready_res;
  logic [tkbd_pkg::AdcBits-1:0]  filtered_level;

  modport source (output valid, output evaluated, output touching, output ready_res,
                  output filtered_level, input ready);
  modport sink (input valid, input evaluated, input touching, input ready_res,
                input filtered_level, output ready);
endinterface

// ===== hw/rtl/touch_key_baseline_detector.sv =====
// Channel   Dir  Payload                                        Handshake
// in_ch     in   adc_sample[11:0]                               valid/ready
// out_ch    out  evaluated, touching, ready_res, filtered_level valid/ready
// apb       in   5-bit paddr, 32-bit pwdata/prdata, 6 registers psel/penable, pready=1
//
// Accumulating tick: accept, then result load. Averaging tick: accept, average,
// multiply, mix, difference, decide and result load; a PI step that only clears the
// integral, or a baseline update through the shared 1-bit/cycle divider that runs
// 32 steps for the proportional and again for the integral term, may come between
// decide and result load.
// Input is taken again as soon as the result is parked in the output register;
// a stalled output holds the block at its result load step.
// Asynchronous active-low reset; no memory, no clearing pass.
module touch_key_baseline_detector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tkbd_in_if.sink                          in_ch,
  tkbd_out_if.source                       out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tkbd_pkg::CfgAddrBits-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  tkbd_pkg::cfg_t       cfg;
  tkbd_pkg::dp_cmd_t    cmd;
  tkbd_pkg::dp_status_t status;

  tkbd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tkbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tkbd_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg),
    .adc_sample_i     (in_ch.adc_sample),
    .status_o         (status),
    .evaluated_o      (out_ch.evaluated),
    .touching_o       (out_ch.touching),
    .ready_res_o      (out_ch.ready_res),
    .filtered_level_o (out_ch.filtered_level)
  );

endmodule

// ===== hw/rtl/tkbd_cfg_regs.sv =====
module tkbd_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tkbd_pkg::CfgAddrBits-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output tkbd_pkg::cfg_t                   cfg_o
);

  tkbd_pkg::cfg_t     cfg_q;
  tkbd_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = tkbd_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_o  = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr   <= 16'd100;
      cfg_q.gain  <= 11'd256;
      cfg_q.prop  <= 16'd16;
      cfg_q.integ <= 16'd64;
      cfg_q.imax  <= 21'd1000;
      cfg_q.imin  <= 21'h1F_FC18;
    end else if (wr_en) begin
      case (idx)
        tkbd_pkg::RegThreshold: cfg_q.thr   <= pwdata[15:0];
        tkbd_pkg::RegGain:      cfg_q.gain  <= pwdata[tkbd_pkg::GainBits-1:0];
        tkbd_pkg::RegPropDiv:   cfg_q.prop  <= pwdata[tkbd_pkg::DenBits-1:0];
        tkbd_pkg::RegIntegDiv:  cfg_q.integ <= pwdata[tkbd_pkg::DenBits-1:0];
        tkbd_pkg::RegIntegMax:  cfg_q.imax  <= pwdata[tkbd_pkg::IntegBits-1:0];
        tkbd_pkg::RegIntegMin:  cfg_q.imin  <= pwdata[tkbd_pkg::IntegBits-1:0];
        default: ;
      endcase
    end
  end

  // Read mux, clamp bounds sign extended
  always_comb begin
    case (idx)
      tkbd_pkg::RegThreshold: prdata = {16'd0, cfg_q.thr};
      tkbd_pkg::RegGain:      prdata = {21'd0, cfg_q.gain};
      tkbd_pkg::RegPropDiv:   prdata = {16'd0, cfg_q.prop};
      tkbd_pkg::RegIntegDiv:  prdata = {16'd0, cfg_q.integ};
      tkbd_pkg::RegIntegMax:  prdata = {{11{cfg_q.imax[20]}}, cfg_q.imax};
      tkbd_pkg::RegIntegMin:  prdata = {{11{cfg_q.imin[20]}}, cfg_q.imin};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/tkbd_div.sv =====
module tkbd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tkbd_pkg::DivBits-1:0]  num_i,
  input  logic [tkbd_pkg::DenBits-1:0]  den_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [tkbd_pkg::DivBits-1:0]  quot_o
);

  logic [tkbd_pkg::DivBits-1:0]    quot_q;
  logic [tkbd_pkg::DenBits-1:0]    rem_q;
  logic [tkbd_pkg::DenBits-1:0]    den_q;
  logic [tkbd_pkg::DivCntBits-1:0] cnt_q;
  logic                            busy_q;
  logic                            done_q;
  logic [tkbd_pkg::DenBits:0]      rem_sh;
  logic [tkbd_pkg::DenBits:0]      rem_sub;
  logic                            fits;

  // One restoring step per cycle while busy
  assign rem_sh  = {rem_q, quot_q[tkbd_pkg::DivBits-1]};
  assign fits    = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == tkbd_pkg::DivCntBits'(tkbd_pkg::DivBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[tkbd_pkg::DivBits-2:0], fits};
      rem_q  <= fits ? rem_sub[tkbd_pkg::DenBits-1:0] : rem_sh[tkbd_pkg::DenBits-1:0];
    end
  end

endmodule

// ===== hw/rtl/tkbd_datapath.sv =====
module tkbd_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tkbd_pkg::dp_cmd_t             cmd_i,
  input  tkbd_pkg::cfg_t                cfg_i,
  input  logic [tkbd_pkg::AdcBits-1:0]  adc_sample_i,
  output tkbd_pkg::dp_status_t          status_o,
  output logic                          evaluated_o,
  output logic                          touching_o,
  output logic                          ready_res_o,
  output logic [tkbd_pkg::AdcBits-1:0]  filtered_level_o
);

  localparam int unsigned ProdABits = tkbd_pkg::GainBits + tkbd_pkg::SumBits;
  localparam int unsigned ProdBBits = tkbd_pkg::GainBits + tkbd_pkg::AdcBits;

  // Tracking state
  logic [tkbd_pkg::SumBits-1:0]   sum_q;
  logic [3:0]                     tick_q;
  logic [tkbd_pkg::AdcBits-1:0]   filt_q;
  logic [tkbd_pkg::DataBits-1:0]  base_q;
  logic [tkbd_pkg::IntegBits-1:0] acc_q;
  logic [3:0]                     settle_q;
  logic                           settled_q;
  logic                           touch_q;
  logic                           grp_q;

  // Working registers
  logic [ProdABits-1:0]           prod_a_q;
  logic [ProdBBits-1:0]           prod_b_q;
  logic [tkbd_pkg::DataBits-1:0]  diff_q;
  logic [tkbd_pkg::DataBits-1:0]  pterm_q;

  // Result payload
  logic                           ev_q;
  logic                           touch_out_q;
  logic                           rdy_out_q;
  logic [tkbd_pkg::AdcBits-1:0]   lvl_q;

  logic [3:0]                     tick_nx;
  logic                           group_end;
  logic [2*tkbd_pkg::SumBits-1:0] avg_prod;
  logic [tkbd_pkg::GainBits-1:0]  gain;
  logic [tkbd_pkg::GainBits-1:0]  gain_inv;
  logic [tkbd_pkg::MixBits-1:0]   mix;
  logic [tkbd_pkg::DataBits-1:0]  d_mag;
  logic                           d_zero;
  logic                           d_gt;
  logic                           touch_nx;
  logic [3:0]                     settle_nx;
  logic signed [32:0]             acc_sum;
  logic signed [32:0]             imin_w;
  logic signed [32:0]             imax_w;
  logic [tkbd_pkg::IntegBits-1:0] acc_clamped;
  logic [tkbd_pkg::IntegBits-1:0] acc_neg;
  logic [tkbd_pkg::DivBits-1:0]   acc_mag;
  logic [tkbd_pkg::DivBits-1:0]   div_num;
  logic [tkbd_pkg::DenBits-1:0]   div_den;
  logic [tkbd_pkg::DivBits-1:0]   quot;
  logic                           div_busy;
  logic                           div_done;
  logic [tkbd_pkg::DataBits-1:0]  pterm_nx;
  logic [tkbd_pkg::DataBits-1:0]  iterm;

  // Group position
  assign tick_nx   = tick_q + 4'd1;
  assign group_end = tick_nx >= tkbd_pkg::GroupLen;

  // Divide by ten through the reciprocal
  assign avg_prod = sum_q * tkbd_pkg::Recip10;

  // Filter gain, saturated at unity
  assign gain     = (cfg_i.gain > tkbd_pkg::GainOne) ? tkbd_pkg::GainOne : cfg_i.gain;
  assign gain_inv = tkbd_pkg::GainOne - gain;
  assign mix      = tkbd_pkg::MixBits'(prod_a_q) + tkbd_pkg::MixBits'(prod_b_q);

  // Difference magnitude and touch decision
  assign d_mag     = diff_q[tkbd_pkg::DataBits-1] ? (32'd0 - diff_q) : diff_q;
  assign d_zero    = diff_q == '0;
  assign d_gt      = d_mag > {16'd0, cfg_i.thr};
  assign touch_nx  = settled_q ? d_gt : touch_q;
  assign settle_nx = settle_q + 4'd1;

  // Integral update with clamp, lower bound checked first
  assign acc_sum = $signed({{12{acc_q[tkbd_pkg::IntegBits-1]}}, acc_q})
                 + $signed({diff_q[tkbd_pkg::DataBits-1], diff_q});
  assign imin_w  = $signed({{12{cfg_i.imin[tkbd_pkg::IntegBits-1]}}, cfg_i.imin});
  assign imax_w  = $signed({{12{cfg_i.imax[tkbd_pkg::IntegBits-1]}}, cfg_i.imax});

  always_comb begin
    if (acc_sum < imin_w) begin
      acc_clamped = cfg_i.imin;
    end else if (acc_sum > imax_w) begin
      acc_clamped = cfg_i.imax;
    end else begin
      acc_clamped = acc_sum[tkbd_pkg::IntegBits-1:0];
    end
  end

  assign acc_neg = '0 - acc_q;
  assign acc_mag = acc_q[tkbd_pkg::IntegBits-1] ?
                   tkbd_pkg::DivBits'(acc_neg) : tkbd_pkg::DivBits'(acc_q);

  // Shared divider: proportional term, then integral term
  assign div_num = cmd_i.div_sel ? acc_mag : d_mag;
  assign div_den = cmd_i.div_sel ? cfg_i.integ : cfg_i.prop;

  tkbd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Sign restore, zero divisor gives a zero term
  always_comb begin
    if (cfg_i.prop == '0) begin
      pterm_nx = '0;
    end else begin
      pterm_nx = diff_q[tkbd_pkg::DataBits-1] ? (32'd0 - quot) : quot;
    end
    if (cfg_i.integ == '0) begin
      iterm = '0;
    end else begin
      iterm = acc_q[tkbd_pkg::IntegBits-1] ? (32'd0 - quot) : quot;
    end
  end

  assign status_o.group_end = group_end;
  assign status_o.take_pi   = !(!settled_q && d_zero) && !touch_nx;
  assign status_o.d_zero    = d_zero;
  assign status_o.div_busy  = div_busy;
  assign status_o.div_done  = div_done;

  assign evaluated_o      = ev_q;
  assign touching_o       = touch_out_q;
  assign ready_res_o      = rdy_out_q;
  assign filtered_level_o = lvl_q;

  // Tracking state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      tick_q    <= '0;
      filt_q    <= '0;
      base_q    <= tkbd_pkg::BaselineReset;
      acc_q     <= '0;
      settle_q  <= '0;
      settled_q <= 1'b0;
      touch_q   <= 1'b0;
      grp_q     <= 1'b0;
    end else begin
      if (cmd_i.tick) begin
        grp_q <= group_end;
        if (group_end) begin
          tick_q <= '0;
        end else begin
          tick_q <= tick_nx;
          sum_q  <= sum_q + tkbd_pkg::SumBits'(adc_sample_i);
        end
      end
      if (cmd_i.avg) begin
        sum_q <= tkbd_pkg::SumBits'(avg_prod[2*tkbd_pkg::SumBits-1:tkbd_pkg::Recip10Shift]);
      end
      if (cmd_i.mix) begin
        filt_q <= mix[tkbd_pkg::GainShift +: tkbd_pkg::AdcBits];
      end
      if (cmd_i.decide) begin
        if (!settled_q && d_zero) begin
          settle_q <= settle_nx;
          if (settle_nx > tkbd_pkg::SettleLimit) begin
            settled_q <= 1'b1;
          end
        end else if (!settled_q) begin
          settle_q <= '0;
        end else begin
          touch_q <= d_gt;
        end
      end
      if (cmd_i.pi_step) begin
        acc_q <= d_zero ? '0 : acc_clamped;
      end
      if (cmd_i.cap_base) begin
        base_q <= base_q + pterm_q + iterm;
      end
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_a_q <= gain * sum_q;
      prod_b_q <= gain_inv * filt_q;
    end
    if (cmd_i.diff) begin
      diff_q <= tkbd_pkg::DataBits'(filt_q) - base_q;
    end
    if (cmd_i.cap_p) begin
      pterm_q <= pterm_nx;
    end
    if (cmd_i.load_out) begin
      ev_q        <= grp_q;
      touch_out_q <= touch_q;
      rdy_out_q   <= settled_q;
      lvl_q       <= filt_q;
    end
  end

  // Once settled the detector never returns to initialising
  a_settled_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settled_q |=> settled_q)
    else $error("settled flag dropped");

  // A touch is only ever flagged after settling
  a_touch_needs_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    touch_q |-> settled_q)
    else $error("touch flagged while initialising");

  // Tick counter stays inside one group
  a_tick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q < tkbd_pkg::GroupLen)
    else $error("tick counter out of group");

endmodule

// ===== hw/rtl/tkbd_ctrl.sv =====
module tkbd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  tkbd_pkg::dp_status_t  status_i,
  output tkbd_pkg::dp_cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    StIdle,
    StAvg,
    StMul,
    StMix,
    StDiff,
    StDecide,
    StPi,
    StDivP,
    StDivIGo,
    StDivI,
    StEmit
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   accept;
  logic   slot_free;

  assign in_ready_o  = state_q == StIdle;
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Command decode and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.tick = 1'b1;
          state_d    = status_i.group_end ? StAvg : StEmit;
        end
      end
      StAvg: begin
        cmd_o.avg = 1'b1;
        state_d   = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StMix;
      end
      StMix: begin
        cmd_o.mix = 1'b1;
        state_d   = StDiff;
      end
      StDiff: begin
        cmd_o.diff = 1'b1;
        state_d    = StDecide;
      end
      StDecide: begin
        cmd_o.decide = 1'b1;
        state_d      = status_i.take_pi ? StPi : StEmit;
      end
      StPi: begin
        cmd_o.pi_step = 1'b1;
        if (status_i.d_zero) begin
          state_d = StEmit;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = StDivP;
        end
      end
      StDivP: begin
        if (status_i.div_done) begin
          cmd_o.cap_p = 1'b1;
          state_d     = StDivIGo;
        end
      end
      StDivIGo: begin
        cmd_o.div_sel   = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = StDivI;
      end
      StDivI: begin
        cmd_o.div_sel = 1'b1;
        if (status_i.div_done) begin
          cmd_o.cap_base = 1'b1;
          state_d        = StEmit;
        end
      end
      StEmit: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Divider is never restarted mid-division
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !status_i.div_busy)
    else $error("divider started while busy");

  // While waiting on a quotient the divider is running or just finished
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivP || state_q == StDivI) |-> (status_i.div_busy || status_i.div_done))
    else $error("waiting on an idle divider");

  // A result is never written over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> slot_free)
    else $error("result register overwritten");

endmodule
